@@ sv/pid_with_antiwindup_defines.svh @@
// Assertion macros for the PID controller with anti-windup.
// Included by the top level; no other dependencies.
`ifndef PID_WITH_ANTIWINDUP_DEFINES_SVH
`define PID_WITH_ANTIWINDUP_DEFINES_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define PID_AW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pid_with_antiwindup: assertion failed");
// checked on every clock edge, reset included
`define PID_AW_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pid_with_antiwindup: assertion failed during reset");
`else
`define PID_AW_ASSERT(lbl, prop)
`define PID_AW_ASSERT_RST(lbl, prop)
`endif

`endif

@@ sv/pid_aw_pkg.sv @@
// Shared constants and codes for the PID controller with anti-windup.
// No dependencies.
`default_nettype none

package pid_aw_pkg;

  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned LimW         = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN       = 3'd0,
    REG_INTEGRAL_GAIN   = 3'd1,
    REG_DERIVATIVE_GAIN = 3'd2,
    REG_WINDUP_GAIN     = 3'd3,
    REG_OUT_MAX         = 3'd4,
    REG_OUT_MIN         = 3'd5
  } cfg_reg_e;

  typedef enum logic [LimW-1:0] {
    LIM_NONE  = 2'd0,
    LIM_UPPER = 2'd1,
    LIM_LOWER = 2'd2
  } limit_e;

endpackage

`default_nettype wire

@@ sv/pid_aw_smul.sv @@
// Saturating fixed-point multiplier: full product, floor shift, clamp.
// No dependencies.
`default_nettype none

module pid_aw_smul #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output logic signed [DATA_WIDTH-1:0] p_o
);

  localparam int unsigned ProdW = 2 * DATA_WIDTH;
  localparam int unsigned ShW   = ProdW - FRAC_BITS;

  logic signed [ProdW-1:0]        prod;
  logic signed [ShW-1:0]          shifted;
  logic [ShW-DATA_WIDTH:0]        hi_bits;

  assign prod    = ProdW'(a_i) * ProdW'(b_i);
  // arithmetic shift = round toward minus infinity
  assign shifted = prod[ProdW-1:FRAC_BITS];
  assign hi_bits = shifted[ShW-1:DATA_WIDTH-1];

  always_comb begin
    if (&hi_bits || ~|hi_bits) begin
      p_o = shifted[DATA_WIDTH-1:0];
    end else if (shifted[ShW-1]) begin
      p_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      p_o = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ sv/pid_aw_err.sv @@
// Input register and error stage: error, error difference, ki * last error.
// Depends on pid_aw_smul.
`default_nettype none

module pid_aw_err #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] target_i,
  input  logic signed [DATA_WIDTH-1:0] measured_i,
  input  logic signed [DATA_WIDTH-1:0] int_gain_i,
  output logic                         dn_valid_o,
  input  logic                         dn_ready_i,
  output logic signed [DATA_WIDTH-1:0] err_o,
  output logic signed [DATA_WIDTH-1:0] diff_o,
  output logic signed [DATA_WIDTH-1:0] ki_o
);

  localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH-1:0] b
  );
    logic [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      sat_sub = s[DATA_WIDTH] ? MinVal : MaxVal;
    end else begin
      sat_sub = s[DATA_WIDTH-1:0];
    end
  endfunction

  logic                         in_vld_q;
  logic signed [DATA_WIDTH-1:0] target_q, measured_q;
  logic                         vld_q;
  logic signed [DATA_WIDTH-1:0] err_q, diff_q, ki_q;
  logic signed [DATA_WIDTH-1:0] last_err_q;
  logic signed [DATA_WIDTH-1:0] err, diff, ki;
  logic                         stg_ready;

  assign stg_ready  = !vld_q || dn_ready_i;
  assign in_ready_o = !in_vld_q || stg_ready;

  assign err  = sat_sub(target_q, measured_q);
  assign diff = sat_sub(err, last_err_q);

  pid_aw_smul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_ki (
    .a_i(int_gain_i),
    .b_i(last_err_q),
    .p_o(ki)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      vld_q      <= 1'b0;
      last_err_q <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (stg_ready) begin
        vld_q <= in_vld_q;
      end
      if (stg_ready && in_vld_q) begin
        last_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      target_q   <= target_i;
      measured_q <= measured_i;
    end
    if (stg_ready && in_vld_q) begin
      err_q  <= err;
      diff_q <= diff;
      ki_q   <= ki;
    end
  end

  assign dn_valid_o = vld_q;
  assign err_o      = err_q;
  assign diff_o     = diff_q;
  assign ki_o       = ki_q;

endmodule

`default_nettype wire

@@ sv/pid_aw_mul.sv @@
// Product stage: proportional and derivative terms, ki term passed along.
// Depends on pid_aw_smul.
`default_nettype none

module pid_aw_mul #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         up_valid_i,
  output logic                         up_ready_o,
  input  logic signed [DATA_WIDTH-1:0] err_i,
  input  logic signed [DATA_WIDTH-1:0] diff_i,
  input  logic signed [DATA_WIDTH-1:0] ki_i,
  input  logic signed [DATA_WIDTH-1:0] prop_gain_i,
  input  logic signed [DATA_WIDTH-1:0] deriv_gain_i,
  output logic                         dn_valid_o,
  input  logic                         dn_ready_i,
  output logic signed [DATA_WIDTH-1:0] p_o,
  output logic signed [DATA_WIDTH-1:0] d_o,
  output logic signed [DATA_WIDTH-1:0] ki_o
);

  logic                         vld_q;
  logic signed [DATA_WIDTH-1:0] p_q, d_q, ki_q;
  logic signed [DATA_WIDTH-1:0] p, d;

  assign up_ready_o = !vld_q || dn_ready_i;

  pid_aw_smul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_p (
    .a_i(prop_gain_i),
    .b_i(err_i),
    .p_o(p)
  );

  pid_aw_smul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_d (
    .a_i(deriv_gain_i),
    .b_i(diff_i),
    .p_o(d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (up_ready_o) begin
      vld_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      p_q  <= p;
      d_q  <= d;
      ki_q <= ki_i;
    end
  end

  assign dn_valid_o = vld_q;
  assign p_o        = p_q;
  assign d_o        = d_q;
  assign ki_o       = ki_q;

endmodule

`default_nettype wire

@@ sv/pid_aw_acc.sv @@
// Integrator, sum, clamp and result register; holds integral and saturation error.
// Depends on pid_aw_pkg and pid_aw_smul.
`default_nettype none

module pid_aw_acc #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           up_valid_i,
  output logic                           up_ready_o,
  input  logic signed [DATA_WIDTH-1:0]   p_i,
  input  logic signed [DATA_WIDTH-1:0]   d_i,
  input  logic signed [DATA_WIDTH-1:0]   ki_i,
  input  logic signed [DATA_WIDTH-1:0]   windup_gain_i,
  input  logic signed [DATA_WIDTH-1:0]   out_max_i,
  input  logic signed [DATA_WIDTH-1:0]   out_min_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [DATA_WIDTH-1:0]   drive_o,
  output logic [pid_aw_pkg::LimW-1:0]    limited_o
);

  import pid_aw_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  function automatic logic signed [DATA_WIDTH-1:0] sat_add(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH-1:0] b
  );
    logic [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      sat_add = s[DATA_WIDTH] ? MinVal : MaxVal;
    end else begin
      sat_add = s[DATA_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
    input logic signed [DATA_WIDTH-1:0] a,
    input logic signed [DATA_WIDTH-1:0] b
  );
    logic [DATA_WIDTH:0] s;
    s = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
      sat_sub = s[DATA_WIDTH] ? MinVal : MaxVal;
    end else begin
      sat_sub = s[DATA_WIDTH-1:0];
    end
  endfunction

  logic                         vld_q;
  logic signed [DATA_WIDTH-1:0] drive_q;
  limit_e                       lim_q;
  logic signed [DATA_WIDTH-1:0] integ_q, lse_q;
  logic signed [DATA_WIDTH-1:0] kw, i_part, i_new, pi_sum, tot, lo_clip, sat, lse;
  limit_e                       code;

  assign up_ready_o = !vld_q || out_ready_i;

  pid_aw_smul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul_kw (
    .a_i(windup_gain_i),
    .b_i(lse_q),
    .p_o(kw)
  );

  // summation order matters: every add saturates
  assign i_part  = sat_add(integ_q, ki_i);
  assign i_new   = sat_add(i_part, kw);
  assign pi_sum  = sat_add(p_i, i_new);
  assign tot     = sat_add(pi_sum, d_i);
  // raise to min first, then lower to max (max wins on inverted limits)
  assign lo_clip = (tot < out_min_i) ? out_min_i : tot;
  assign sat     = (lo_clip > out_max_i) ? out_max_i : lo_clip;
  assign lse     = sat_sub(sat, tot);

  always_comb begin
    if (sat < tot) begin
      code = LIM_UPPER;
    end else if (sat > tot) begin
      code = LIM_LOWER;
    end else begin
      code = LIM_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      integ_q <= '0;
      lse_q   <= '0;
    end else begin
      if (up_ready_o) begin
        vld_q <= up_valid_i;
      end
      if (up_valid_i && up_ready_o) begin
        integ_q <= i_new;
        lse_q   <= lse;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      drive_q <= sat;
      lim_q   <= code;
    end
  end

  assign out_valid_o = vld_q;
  assign drive_o     = drive_q;
  assign limited_o   = lim_q;

endmodule

`default_nettype wire

@@ sv/pid_with_antiwindup.sv @@
// Top level of the PID controller with back-calculation anti-windup.
// Depends on pid_aw_pkg, pid_aw_err, pid_aw_mul, pid_aw_acc, the defines header.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one item: target_i, measured_i,
//    signed fixed point with FRAC_BITS fraction bits.
//  - Output channel (out_valid_o/out_ready_i) returns one item per input item:
//    drive_o, clamped to [out_min, out_max] (out_max if inverted), and limited_o (none/upper/lower).
//  - Config channel (cfg_valid_i/cfg_ready_o) writes gain and limit registers by
//    index; always ready, writes to unused indexes are dropped. Write only idle.
//  - Path: an accepted item passes the input register, the error stage, the product
//    stage and the result register, in that order, before its result is valid.
//  - Throughput: 1 item per cycle while out_ready_i stays high. The integrator/clamp feedback
//    (windup product, four saturating adds, clamp) closes inside the result stage.
//  - Stall: ready ripples back stage by stage; up to four items sit in the
//    pipeline while out_ready_i is low, and nothing is dropped or repeated.
//  - Reset: gains go to zero, limits to full range, last error, integral and
//    saturation error clear, pipeline empties. No clearing pass needed.
`default_nettype none

`include "pid_with_antiwindup_defines.svh"

module pid_with_antiwindup #(
  parameter int unsigned DATA_WIDTH = pid_aw_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = pid_aw_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pid_aw_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [DATA_WIDTH-1:0]             cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]      target_i,
  input  logic signed [DATA_WIDTH-1:0]      measured_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [DATA_WIDTH-1:0]      drive_o,
  output logic [pid_aw_pkg::LimW-1:0]       limited_o
);

  import pid_aw_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] MaxVal = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // configuration registers
  logic signed [DATA_WIDTH-1:0] prop_gain_q, int_gain_q, deriv_gain_q, windup_gain_q;
  logic signed [DATA_WIDTH-1:0] out_max_q, out_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      int_gain_q    <= '0;
      deriv_gain_q  <= '0;
      windup_gain_q <= '0;
      out_max_q     <= MaxVal;
      out_min_q     <= MinVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PROP_GAIN:       prop_gain_q   <= cfg_data_i;
        REG_INTEGRAL_GAIN:   int_gain_q    <= cfg_data_i;
        REG_DERIVATIVE_GAIN: deriv_gain_q  <= cfg_data_i;
        REG_WINDUP_GAIN:     windup_gain_q <= cfg_data_i;
        REG_OUT_MAX:         out_max_q     <= cfg_data_i;
        REG_OUT_MIN:         out_min_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // error stage -> product stage
  logic                         e2m_valid, e2m_ready;
  logic signed [DATA_WIDTH-1:0] e2m_err, e2m_diff, e2m_ki;
  // product stage -> result stage
  logic                         m2a_valid, m2a_ready;
  logic signed [DATA_WIDTH-1:0] m2a_p, m2a_d, m2a_ki;

  pid_aw_err #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_err (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .target_i  (target_i),
    .measured_i(measured_i),
    .int_gain_i(int_gain_q),
    .dn_valid_o(e2m_valid),
    .dn_ready_i(e2m_ready),
    .err_o     (e2m_err),
    .diff_o    (e2m_diff),
    .ki_o      (e2m_ki)
  );

  pid_aw_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .up_valid_i  (e2m_valid),
    .up_ready_o  (e2m_ready),
    .err_i       (e2m_err),
    .diff_i      (e2m_diff),
    .ki_i        (e2m_ki),
    .prop_gain_i (prop_gain_q),
    .deriv_gain_i(deriv_gain_q),
    .dn_valid_o  (m2a_valid),
    .dn_ready_i  (m2a_ready),
    .p_o         (m2a_p),
    .d_o         (m2a_d),
    .ki_o        (m2a_ki)
  );

  pid_aw_acc #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (m2a_valid),
    .up_ready_o   (m2a_ready),
    .p_i          (m2a_p),
    .d_i          (m2a_d),
    .ki_i         (m2a_ki),
    .windup_gain_i(windup_gain_q),
    .out_max_i    (out_max_q),
    .out_min_i    (out_min_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o),
    .limited_o    (limited_o)
  );

  // no result may be presented while reset is held
  `PID_AW_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid_o)
  // upper clamp always lands exactly on the upper limit
  `PID_AW_ASSERT(a_upper_hits_max, out_valid_o && limited_o == LIM_UPPER |-> drive_o == out_max_q)
  // with ordered limits the drive stays inside them
  `PID_AW_ASSERT(a_drive_in_range, out_valid_o && out_min_q <= out_max_q |-> drive_o >= out_min_q && drive_o <= out_max_q)

endmodule

`default_nettype wire

@@ tb/tb_pid_with_antiwindup.sv @@
// Self-checking testbench for pid_with_antiwindup: a table of directed samples,
// then randomized phases, each result checked against a typed-in value or a cycle-free PID predictor.
// Depends on pid_aw_pkg and the pid_with_antiwindup RTL.
`default_nettype none

module tb_pid_with_antiwindup;
  timeunit 1ns;
  timeprecision 1ps;

  import pid_aw_pkg::*;

  localparam int W        = 32;
  localparam int FB       = 16;
  localparam int IDLE_PCT = 8;     // idle chance per cycle, each side
  localparam int HOLD_LEN = 64;    // receiver back-pressure stretch
  localparam int STALL_MAX = 2000; // cycles with no handshake before giving up
  localparam int PHASES   = 10;
  localparam int PHASE_ITEMS = 53;

  typedef logic signed [W-1:0]     word_t;
  typedef logic signed [2*W+1:0]   wide_t;

  // unused register indexes, writes to them must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  localparam word_t WMAX  = 32'sh7FFF_FFFF;
  localparam word_t WMIN  = 32'sh8000_0000;
  localparam word_t ONE   = 32'sh0001_0000;
  localparam word_t NEG1  = 32'shFFFF_0000;
  localparam word_t HALF  = 32'sh0000_8000;
  localparam word_t QUART = 32'sh0000_4000;
  localparam word_t EIGHT = 32'sh0000_2000;
  localparam word_t P200  = 32'sh00C8_0000;
  localparam word_t P100  = 32'sh0064_0000;
  localparam word_t P300  = 32'sh012C_0000;
  localparam word_t M100  = 32'shFF9C_0000;
  localparam word_t M200  = 32'shFF38_0000;
  localparam word_t P10   = 32'sh000A_0000;
  localparam word_t M10   = 32'shFFF6_0000;
  localparam word_t P50   = 32'sh0032_0000;
  localparam word_t M50   = 32'shFFCE_0000;

  typedef struct packed {
    word_t  drive;
    limit_e lim;
  } result_t;

  // directed sample: group selects the register setting loaded before it;
  // known rows carry a typed-in result, the rest go through the predictor
  typedef struct packed {
    logic [3:0] grp;
    word_t      tgt;
    word_t      meas;
    logic       known;
    word_t      drv;
    limit_e     lim;
  } probe_t;

  localparam int PROBE_N = 21;
  localparam probe_t PROBES [PROBE_N] = '{
    // reset setting: zero gains, full range -> always zero, within limits
    '{4'd0, 32'sh0, 32'sh0, 1'b1, 32'sh0, LIM_NONE},
    '{4'd0, WMAX,   WMIN,   1'b1, 32'sh0, LIM_NONE},
    '{4'd0, WMIN,   WMAX,   1'b1, 32'sh0, LIM_NONE},
    '{4'd0, WMAX,   WMAX,   1'b1, 32'sh0, LIM_NONE},
    '{4'd0, WMIN,   WMIN,   1'b1, 32'sh0, LIM_NONE},
    // window above zero: raised to the lower limit
    '{4'd1, 32'sh0, 32'sh0, 1'b1, P100,   LIM_LOWER},
    '{4'd1, WMAX,   WMIN,   1'b1, P100,   LIM_LOWER},
    // inverted limits: raised to out_min, then lowered to out_max
    '{4'd2, WMIN,   32'sh0, 1'b1, P200,   LIM_LOWER},
    // window below zero: lowered to the upper limit
    '{4'd3, WMAX,   32'sh0, 1'b1, M100,   LIM_UPPER},
    // unit proportional gain, saturated and in-range error
    '{4'd4, WMAX,   WMIN,   1'b0, 32'sh0, LIM_NONE},
    '{4'd4, WMIN,   WMAX,   1'b0, 32'sh0, LIM_NONE},
    '{4'd4, 32'sh0005_8000, 32'sh0002_4000, 1'b0, 32'sh0, LIM_NONE},
    // extreme gains: the products saturate on the large errors
    '{4'd5, WMAX,   WMIN,   1'b0, 32'sh0, LIM_NONE},
    '{4'd5, WMIN,   WMAX,   1'b0, 32'sh0, LIM_NONE},
    '{4'd5, 32'sh0, 32'sh0, 1'b0, 32'sh0, LIM_NONE},
    // tight window with back-calculation: steps that wind the integrator
    '{4'd6, P50,    32'sh0, 1'b0, 32'sh0, LIM_NONE},
    '{4'd6, P50,    32'sh0, 1'b0, 32'sh0, LIM_NONE},
    '{4'd6, P50,    32'sh0, 1'b0, 32'sh0, LIM_NONE},
    '{4'd6, M50,    32'sh0, 1'b0, 32'sh0, LIM_NONE},
    '{4'd6, M50,    32'sh0, 1'b0, 32'sh0, LIM_NONE},
    '{4'd6, 32'sh0, 32'sh0, 1'b0, 32'sh0, LIM_NONE}
  };

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [W-1:0]       cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  word_t              target_i;
  word_t              measured_i;
  logic               out_valid_o;
  logic               out_ready_i;
  word_t              drive_o;
  logic [LimW-1:0]    limited_o;

  pid_with_antiwindup DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .target_i    (target_i),
    .measured_i  (measured_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .drive_o     (drive_o),
    .limited_o   (limited_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of gains, limits and controller history
  // ---------------------------------------------------------------------------
  word_t kp_q = '0, ki_q = '0, kd_q = '0, kw_q = '0;
  word_t hi_lim = WMAX, lo_lim = WMIN;
  word_t err_hist = '0, integ_acc = '0, sat_hist = '0;

  result_t pending_drive [$];  // expected results, oldest first
  int      mismatches = 0;
  bit      calm = 1'b0;        // no idling on either side while set
  int      hold_asks = 0;      // bumped by the stimulus to ask for a hold-off
  int      hold_served = 0;    // owned by the receiver process
  int      stall_cycles = 0;

  function automatic word_t clip_word(input wide_t v);
    if (v > wide_t'(WMAX)) return WMAX;
    if (v < wide_t'(WMIN)) return WMIN;
    return v[W-1:0];
  endfunction

  function automatic word_t sat_sum(input word_t a, input word_t b);
    return clip_word(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic word_t sat_diff(input word_t a, input word_t b);
    return clip_word(wide_t'(a) - wide_t'(b));
  endfunction

  // exact product, floor shift by the fraction bits, then saturate
  function automatic word_t fx_prod(input word_t a, input word_t b);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    p = p >>> FB;
    return clip_word(p);
  endfunction

  // one control step; advances the predictor history
  task automatic pid_predict(input word_t tgt, input word_t meas, output result_t res);
    word_t err, p_term, i_term, d_term, total, held;
    err    = sat_diff(tgt, meas);
    p_term = fx_prod(kp_q, err);
    i_term = sat_sum(integ_acc, fx_prod(ki_q, err_hist));
    d_term = fx_prod(kd_q, sat_diff(err, err_hist));
    i_term = sat_sum(i_term, fx_prod(kw_q, sat_hist));
    total  = sat_sum(sat_sum(p_term, i_term), d_term);
    // lower bound first, so inverted limits end on out_max
    held = (total < lo_lim) ? lo_lim : total;
    held = (held > hi_lim) ? hi_lim : held;
    res.drive = held;
    if (held < total)      res.lim = LIM_UPPER;
    else if (held > total) res.lim = LIM_LOWER;
    else                   res.lim = LIM_NONE;
    sat_hist  = sat_diff(held, total);
    err_hist  = err;
    integ_acc = i_term;
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers (inputs move on the falling edge, handshakes sampled on the rising)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input word_t val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_PROP_GAIN:       kp_q   = val;
      REG_INTEGRAL_GAIN:   ki_q   = val;
      REG_DERIVATIVE_GAIN: kd_q   = val;
      REG_WINDUP_GAIN:     kw_q   = val;
      REG_OUT_MAX:         hi_lim = val;
      REG_OUT_MIN:         lo_lim = val;
      default: ;  // spare index: dropped by the block
    endcase
  endtask

  // full register setting, optionally with a write to a spare index mixed in
  task automatic load_setting(input word_t kp, input word_t ki, input word_t kd,
                              input word_t kw, input word_t hi, input word_t lo,
                              input bit spare);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEGRAL_GAIN, ki);
    write_reg(REG_DERIVATIVE_GAIN, kd);
    if (spare) write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                         word_t'($urandom()));
    write_reg(REG_WINDUP_GAIN, kw);
    write_reg(REG_OUT_MAX, hi);
    write_reg(REG_OUT_MIN, lo);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one sample; on acceptance record its expected result
  task automatic offer_sample(input word_t tgt, input word_t meas, input bit known,
                              input word_t kdrv, input limit_e klim);
    result_t res;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      target_i   = word_t'($urandom());  // noise while not valid
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    target_i   = tgt;
    measured_i = meas;
    do @(posedge clk_i); while (!in_ready_o);
    pid_predict(tgt, meas, res);
    if (known) begin
      res.drive = kdrv;
      res.lim   = klim;
    end
    pending_drive.push_back(res);
  endtask

  // sender pause: stop offering and let every pending result come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk_i);
  endtask

  function automatic word_t rand_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 4))
        0: return WMAX;
        1: return WMIN;
        2: return '0;
        3: return ONE;
        default: return NEG1;
      endcase
    end
    if (r < 25) return word_t'($urandom());
    // moderate: within +/-4.0
    return word_t'($urandom_range(0, 8 << FB)) - word_t'(4 << FB);
  endfunction

  function automatic word_t rand_level();
    // within +/-100.0
    return word_t'($urandom_range(0, 200 << FB)) - word_t'(100 << FB);
  endfunction

  function automatic word_t rand_input();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2, 3: return word_t'($urandom());
      default: return rand_level();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus a long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : drive_sink
    int cnt;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served++;
        out_ready_i = 1'b0;
        for (cnt = 1; cnt < HOLD_LEN; cnt++) @(negedge clk_i);
      end else begin
        out_ready_i = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : score
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_drive.size() == 0) begin
        flag_mismatch($sformatf("unexpected result drive=%0d limited=%0d",
                                drive_o, limited_o));
      end else begin
        want = pending_drive.pop_front();
        if (drive_o !== want.drive || limited_o !== want.lim) begin
          flag_mismatch($sformatf("drive exp %0d got %0d, limited exp %0d got %0d",
                                  want.drive, drive_o, want.lim, limited_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: cycles with no handshake on any channel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_MAX) @(posedge clk_i);
    $display("pid_with_antiwindup verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int    cur_grp;
    word_t hi, lo, tgt, meas, span;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    target_i    = '0;
    measured_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table; a new group drains the pipe and loads its setting
    cur_grp = 0;
    for (int n = 0; n < PROBE_N; n++) begin
      if (int'(PROBES[n].grp) != cur_grp) begin
        cur_grp = int'(PROBES[n].grp);
        settle();
        case (cur_grp)
          1: load_setting('0, '0, '0, '0, P200, P100, 1'b0);
          2: load_setting('0, '0, '0, '0, P200, P300, 1'b0);
          3: load_setting('0, '0, '0, '0, M100, M200, 1'b0);
          4: load_setting(ONE, '0, '0, '0, WMAX, WMIN, 1'b0);
          5: load_setting(WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 1'b0);
          default: load_setting(NEG1, QUART, HALF, EIGHT, P10, M10, 1'b1);
        endcase
      end
      offer_sample(PROBES[n].tgt, PROBES[n].meas, PROBES[n].known,
                   PROBES[n].drv, PROBES[n].lim);
    end

    // random phases: new setting each phase, mostly a plant that tracks its
    // setpoint so the integrator and clamp see long runs, plus noise
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      calm = (ph == 4);
      case ($urandom_range(0, 9))
        0: begin
          hi = WMAX;
          lo = WMIN;
        end
        1: begin  // inverted window
          lo = rand_level();
          hi = lo - word_t'($urandom_range(1, 50 << FB));
        end
        2: begin
          hi = word_t'($urandom());
          lo = word_t'($urandom());
        end
        default: begin
          lo = word_t'($urandom_range(0, 100 << FB)) - word_t'(50 << FB);
          hi = lo + word_t'($urandom_range(0, 100 << FB));
        end
      endcase
      load_setting(rand_gain(), rand_gain(), rand_gain(), rand_gain(), hi, lo,
                   $urandom_range(0, 2) == 0);

      tgt  = rand_level();
      meas = rand_level();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // receiver hold-off while the sender keeps pushing
        if (ph == 2 && k == 5) hold_asks++;
        if ($urandom_range(0, 9) == 0) tgt = rand_level();
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            tgt  = rand_input();
            meas = rand_input();
          end
          3, 4, 5, 6: begin
            tgt  = rand_level();
            meas = rand_level();
          end
          default: begin
            span = word_t'($urandom_range(0, 1 << FB)) - word_t'(1 << (FB - 1));
            meas = meas + ((tgt - meas) >>> 3) + span;
          end
        endcase
        offer_sample(tgt, meas, 1'b0, '0, LIM_NONE);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (pending_drive.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_drive.size()));

    if (mismatches == 0) begin
      $display("pid_with_antiwindup verification clean");
    end else begin
      $display("pid_with_antiwindup verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/pid_aw_pkg.sv
sv/pid_aw_smul.sv
sv/pid_aw_err.sv
sv/pid_aw_mul.sv
sv/pid_aw_acc.sv
sv/pid_with_antiwindup.sv
tb/tb_pid_with_antiwindup.sv
